FILE: sv/tts_pkg.sv
// Shared constants and types of the tick task scheduler.
`default_nettype none
package tts_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_TASKS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 16;

    // Fixed field widths of the channels
    localparam int SLOT_W     = 4;
    localparam int FIELD_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASKS  = 1'b1;

    // Selection policies (any other code acts as least slack)
    localparam logic [1:0] POL_SRT = 2'd0;
    localparam logic [1:0] POL_EDF = 2'd1;
    localparam logic [1:0] POL_LST = 2'd2;

    localparam logic [1:0] POLICY_RESET = POL_EDF;
    localparam logic [4:0] TASKS_RESET  = 5'd1;

    // Classified request handed from the front end to the engine
    typedef struct packed {
        logic               is_tick;
        logic               slot_ok;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] release_time;
        logic [FIELD_W-1:0] exec_time;
        logic [FIELD_W-1:0] first_deadline;
        logic [FIELD_W-1:0] period;
        logic               preemptible;
    } t_item;

endpackage
`default_nettype wire

FILE: sv/tts_in_if.sv
// Input request channel: valid/ready with the task load or tick payload.
`default_nettype none
interface tts_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [tts_pkg::SLOT_W-1:0]  task_slot;
    logic [tts_pkg::FIELD_W-1:0] release_time;
    logic [tts_pkg::FIELD_W-1:0] exec_time;
    logic [tts_pkg::FIELD_W-1:0] first_deadline;
    logic [tts_pkg::FIELD_W-1:0] period;
    logic                        preemptible;

    modport source (output valid, cmd, task_slot, release_time, exec_time,
                    first_deadline, period, preemptible, input ready);
    modport sink (input valid, cmd, task_slot, release_time, exec_time,
                  first_deadline, period, preemptible, output ready);
endinterface
`default_nettype wire

FILE: sv/tts_out_if.sv
// Output result channel: valid/ready with the per-tick report.
`default_nettype none
interface tts_out_if;
    logic                        valid;
    logic                        ready;
    logic                        busy_res;
    logic [tts_pkg::SLOT_W-1:0]  running_task;
    logic                        switched;
    logic                        job_done;
    logic                        deadline_met;
    logic [tts_pkg::FIELD_W-1:0] wait_ticks;
    logic                        queue_overflow;
    logic [tts_pkg::FIELD_W-1:0] tick_time;

    modport source (output valid, busy_res, running_task, switched, job_done,
                    deadline_met, wait_ticks, queue_overflow, tick_time,
                    input ready);
    modport sink (input valid, busy_res, running_task, switched, job_done,
                  deadline_met, wait_ticks, queue_overflow, tick_time,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/tts_front.sv
// Front end: accept requests, classify them and buffer them in a small queue.
`default_nettype none
module tts_front #(
    parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    tts_in_if.sink              i_in,
    output tts_pkg::t_item      o_item,
    output logic                o_item_valid,
    input  wire logic           i_item_pop
);
    logic [1:0]     r_cnt;
    logic           r_wp;
    logic           r_rp;
    tts_pkg::t_item r_buf [2];
    tts_pkg::t_item w_item;
    logic           w_push;

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;

    // Classify the incoming request
    always_comb begin
        w_item.is_tick        = (i_in.cmd == tts_pkg::CMD_TICK);
        w_item.slot_ok        = (7'(i_in.task_slot) < 7'(MAX_TASKS));
        w_item.slot           = i_in.task_slot;
        w_item.release_time   = i_in.release_time;
        w_item.exec_time      = i_in.exec_time;
        w_item.first_deadline = i_in.first_deadline;
        w_item.period         = i_in.period;
        w_item.preemptible    = i_in.preemptible;
    end

    // Write the buffer
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_item;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_item_pop);
        end
    end

    assign o_item       = r_buf[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);
endmodule
`default_nettype wire

FILE: sv/tts_engine.sv
// Back end: task table, job queue, release scan, job selection and result register.
`default_nettype none
module tts_engine #(
    parameter int MAX_TASKS   = tts_pkg::MAX_TASKS_DEF,
    parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = tts_pkg::TIME_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tts_pkg::t_item                 i_item,
    input  wire logic                           i_item_valid,
    output logic                                o_item_pop,
    input  wire logic                           i_cfg_we,
    input  wire logic [tts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tts_out_if.source                           o_out
);
    localparam int TB = TIME_BITS;
    localparam int KW = TIME_BITS + 2;
    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(MAX_TASKS + 1);

    typedef struct packed {
        logic [TB-1:0] nrel;
        logic [TB-1:0] exec;
        logic [TB-1:0] dl;
        logic [TB-1:0] per;
        logic          pre;
    } t_task;

    typedef struct packed {
        logic [SW-1:0] tsk;
        logic [TB-1:0] rem;
        logic [TB-1:0] dl;
        logic [TB-1:0] rel;
    } t_job;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_REL_RD   = 13'b0000000000010,
        S_REL_EX   = 13'b0000000000100,
        S_PRE_Q    = 13'b0000000001000,
        S_PRE_T    = 13'b0000000010000,
        S_PRE_C    = 13'b0000000100000,
        S_SCAN_RD  = 13'b0000001000000,
        S_SCAN_CMP = 13'b0000010000000,
        S_EXE_RD   = 13'b0000100000000,
        S_EXE      = 13'b0001000000000,
        S_SH_RD    = 13'b0010000000000,
        S_SH_WR    = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } t_state;

    function automatic logic [TB-1:0] to_time(input logic [tts_pkg::FIELD_W-1:0] x);
        logic [31:0] v;
        v = 32'(x);
        return v[TB-1:0];
    endfunction

    // Configuration
    logic [1:0]    r_policy;
    logic [4:0]    r_tasks;

    // Control state
    t_state        r_state;
    t_state        n_state;
    logic [MAX_TASKS-1:0] r_pend;
    logic [TB-1:0] r_now;
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_cur;
    logic          r_inprog;
    logic [SW-1:0] r_last;
    logic          r_lastv;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_n;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_j;
    logic          r_first;
    t_job          r_best;
    logic [QW-1:0] r_pick;
    logic signed [KW-1:0] r_bkey;

    // Pending result
    logic          r_busy;
    logic [SW-1:0] r_rtask;
    logic          r_sw;
    logic          r_done;
    logic          r_met;
    logic [15:0]   r_wait;
    logic          r_ovf;

    // Output register
    logic          r_ov;
    logic          r_o_busy;
    logic [3:0]    r_o_task;
    logic          r_o_sw;
    logic          r_o_done;
    logic          r_o_met;
    logic [15:0]   r_o_wait;
    logic          r_o_ovf;
    logic [15:0]   r_o_time;

    // Memories
    t_task         r_tmem [MAX_TASKS];
    t_task         r_trd;
    t_job          r_qmem [QUEUE_DEPTH];
    t_job          r_qrd;

    logic          t_we;
    logic [SW-1:0] t_waddr;
    t_task         t_wdata;
    logic [SW-1:0] t_raddr;
    logic          q_we;
    logic [QW-1:0] q_waddr;
    t_job          q_wdata;
    logic [QW-1:0] q_raddr;

    // Helper values
    logic [6:0]    w_slot7;
    logic [6:0]    w_tu7;
    logic [IW-1:0] w_nscan;
    logic          w_due;
    logic [TB-1:0] w_nr;
    logic [TB-1:0] w_dl;
    logic          w_qroom;
    logic signed [KW-1:0] w_key;
    logic          w_better;
    logic [TB-1:0] w_fin;
    logic [31:0]   w_diff;
    logic          w_out_ld;
    logic [7:0]    w_task8;
    logic [31:0]   w_now32;
    logic [CW-1:0] w_j1;

    assign w_slot7 = 7'(i_item.slot);
    assign w_tu7   = 7'(r_tasks);
    assign w_nscan = (w_tu7 > 7'(MAX_TASKS)) ? IW'(MAX_TASKS) : IW'(w_tu7);
    assign w_due   = r_pend[r_i[SW-1:0]] && (r_trd.nrel <= r_now);
    assign w_nr    = r_trd.nrel + r_trd.per;
    assign w_dl    = (r_trd.per == '0) ? r_trd.dl : w_nr;
    assign w_qroom = (r_cnt < CW'(QUEUE_DEPTH));
    assign w_fin   = r_now + 1'b1;
    assign w_diff  = 32'(w_fin) - 32'(r_best.rel) - 32'(r_trd.exec);
    assign w_out_ld = (r_state == S_OUT) && (!r_ov || o_out.ready);
    assign w_task8 = 8'(r_rtask);
    assign w_now32 = 32'(r_now);
    assign w_j1    = r_j + 1'b1;

    // Selection key of the job just read
    always_comb begin
        unique case (r_policy)
            tts_pkg::POL_SRT: w_key = KW'(r_qrd.rem);
            tts_pkg::POL_EDF: w_key = KW'(r_qrd.dl);
            default:          w_key = KW'(r_qrd.dl) - KW'(r_now) - KW'(r_qrd.rem);
        endcase
        w_better = r_first || (w_key < r_bkey) ||
                   ((w_key == r_bkey) && (r_qrd.tsk < r_best.tsk));
    end

    // Memory port control and next state
    always_comb begin
        n_state    = r_state;
        o_item_pop = 1'b0;
        t_we       = 1'b0;
        t_waddr    = r_i[SW-1:0];
        t_wdata    = r_trd;
        t_raddr    = r_best.tsk;
        q_we       = 1'b0;
        q_waddr    = r_cnt[QW-1:0];
        q_wdata    = r_qrd;
        q_raddr    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.is_tick) begin
                        n_state = S_REL_RD;
                    end else begin
                        o_item_pop = 1'b1;
                        t_we       = i_item.slot_ok;
                        t_waddr    = w_slot7[SW-1:0];
                        t_wdata    = '{nrel: to_time(i_item.release_time),
                                       exec: to_time(i_item.exec_time),
                                       dl:   to_time(i_item.first_deadline),
                                       per:  to_time(i_item.period),
                                       pre:  i_item.preemptible};
                    end
                end
            end
            S_REL_RD: begin
                t_raddr = r_i[SW-1:0];
                if (r_i < r_n) begin
                    n_state = S_REL_EX;
                end else if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PRE_Q;
                end
            end
            S_REL_EX: begin
                if (w_due) begin
                    t_we         = (r_trd.per != '0);
                    t_wdata.nrel = w_nr;
                    q_we         = w_qroom;
                    q_wdata      = '{tsk: r_i[SW-1:0], rem: r_trd.exec, dl: w_dl,
                                     rel: r_trd.nrel};
                end
                n_state = S_REL_RD;
            end
            S_PRE_Q: begin
                q_raddr = r_cur;
                if (r_inprog && (CW'(r_cur) < r_cnt)) begin
                    n_state = S_PRE_T;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_PRE_T: begin
                t_raddr = r_qrd.tsk;
                n_state = S_PRE_C;
            end
            S_PRE_C: begin
                n_state = r_trd.pre ? S_SCAN_RD : S_EXE;
            end
            S_SCAN_RD: begin
                q_raddr = r_k[QW-1:0];
                n_state = (r_k < r_cnt) ? S_SCAN_CMP : S_EXE_RD;
            end
            S_SCAN_CMP: begin
                n_state = S_SCAN_RD;
            end
            S_EXE_RD: begin
                n_state = S_EXE;
            end
            S_EXE: begin
                if (r_best.rem <= TB'(1)) begin
                    n_state = S_SH_RD;
                end else begin
                    q_we        = 1'b1;
                    q_waddr     = r_pick;
                    q_wdata     = r_best;
                    q_wdata.rem = r_best.rem - 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_SH_RD: begin
                q_raddr = w_j1[QW-1:0];
                n_state = (w_j1 < r_cnt) ? S_SH_WR : S_OUT;
            end
            S_SH_WR: begin
                q_we    = 1'b1;
                q_waddr = r_j[QW-1:0];
                n_state = S_SH_RD;
            end
            S_OUT: begin
                if (w_out_ld) begin
                    o_item_pop = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Task table and job queue storage
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_waddr] <= t_wdata;
        end
        r_trd <= r_tmem[t_raddr];
        if (q_we) begin
            r_qmem[q_waddr] <= q_wdata;
        end
        r_qrd <= r_qmem[q_raddr];
    end

    // Scheduler control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= tts_pkg::POLICY_RESET;
            r_tasks  <= tts_pkg::TASKS_RESET;
            r_pend   <= '0;
            r_now    <= '0;
            r_cnt    <= '0;
            r_cur    <= '0;
            r_inprog <= 1'b0;
            r_last   <= '0;
            r_lastv  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == tts_pkg::CFG_POLICY) begin
                    r_policy <= i_cfg_data[1:0];
                end else begin
                    r_tasks <= i_cfg_data[4:0];
                end
            end
            // Mark a loaded slot pending
            if (r_state == S_IDLE && i_item_valid && !i_item.is_tick && i_item.slot_ok) begin
                r_pend[w_slot7[SW-1:0]] <= 1'b1;
            end
            // Release one task
            if (r_state == S_REL_EX && w_due) begin
                if (r_trd.per == '0) begin
                    r_pend[r_i[SW-1:0]] <= 1'b0;
                end
                if (w_qroom) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            // Idle tick drops the running job
            if (r_state == S_REL_RD && !(r_i < r_n) && r_cnt == '0) begin
                r_inprog <= 1'b0;
                r_lastv  <= 1'b0;
            end
            // Run the picked job
            if (r_state == S_EXE) begin
                if (r_best.rem <= TB'(1)) begin
                    r_inprog <= 1'b0;
                    r_cur    <= '0;
                    r_lastv  <= 1'b0;
                end else begin
                    r_inprog <= 1'b1;
                    r_cur    <= r_pick;
                    r_last   <= r_best.tsk;
                    r_lastv  <= 1'b1;
                end
            end
            // Drop the finished job from the queue
            if (r_state == S_SH_RD && !(w_j1 < r_cnt)) begin
                r_cnt <= r_cnt - 1'b1;
            end
            // Hand the result to the output register and advance time
            if (w_out_ld) begin
                r_ov  <= 1'b1;
                r_now <= r_now + 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Scan counters, selection and result payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_i    <= '0;
                r_n    <= w_nscan;
                r_ovf  <= 1'b0;
                r_busy <= 1'b0;
                r_rtask <= '0;
                r_sw   <= 1'b0;
                r_done <= 1'b0;
                r_met  <= 1'b0;
                r_wait <= '0;
            end
            S_REL_EX: begin
                r_i <= r_i + 1'b1;
                if (w_due && !w_qroom) begin
                    r_ovf <= 1'b1;
                end
            end
            S_PRE_Q: begin
                r_k     <= '0;
                r_first <= 1'b1;
            end
            S_PRE_T: begin
                r_best <= r_qrd;
                r_pick <= r_cur;
            end
            S_SCAN_CMP: begin
                if (w_better) begin
                    r_best <= r_qrd;
                    r_pick <= r_k[QW-1:0];
                    r_bkey <= w_key;
                end
                r_first <= 1'b0;
                r_k     <= r_k + 1'b1;
            end
            S_EXE: begin
                r_busy  <= 1'b1;
                r_rtask <= r_best.tsk;
                r_sw    <= !r_lastv || (r_last != r_best.tsk);
                r_j     <= CW'(r_pick);
                if (r_best.rem <= TB'(1)) begin
                    r_done <= 1'b1;
                    r_met  <= (w_fin <= r_best.dl);
                    r_wait <= w_diff[15:0];
                end
            end
            S_SH_WR: begin
                r_j <= w_j1;
            end
            default: begin
            end
        endcase
        if (w_out_ld) begin
            r_o_busy <= r_busy;
            r_o_task <= w_task8[3:0];
            r_o_sw   <= r_sw;
            r_o_done <= r_done;
            r_o_met  <= r_met;
            r_o_wait <= r_wait;
            r_o_ovf  <= r_ovf;
            r_o_time <= w_now32[15:0];
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.busy_res       = r_o_busy;
    assign o_out.running_task   = r_o_task;
    assign o_out.switched       = r_o_sw;
    assign o_out.job_done       = r_o_done;
    assign o_out.deadline_met   = r_o_met;
    assign o_out.wait_ticks     = r_o_wait;
    assign o_out.queue_overflow = r_o_ovf;
    assign o_out.tick_time      = r_o_time;
endmodule
`default_nettype wire

FILE: sv/tick_task_scheduler_core.sv
// Top level of the tick task scheduler: front end and scheduling engine.
//
// Usage: requests arrive on i_in (valid/ready). cmd = load writes one task
// slot (release, execution time, deadline, period, preemptible) and gives no
// result; cmd = tick releases due tasks into the job queue, picks a job by
// the policy register (shortest remaining, earliest deadline, least slack)
// and runs it for one tick, giving one result on o_out (valid/ready).
// Configuration (policy, tasks_in_use) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data while no request is in flight.
// A load is written into the task table in the same cycle as it leaves the
// buffer. A tick scans the N task slots in use for releases, checks the job
// in progress when there is one, scans the J queued jobs to select one and,
// when a job finishes, shifts the later jobs down; the task table and job
// queue each have one read port and are walked one entry at a time.
// Requests are buffered two deep ahead of the engine.
// Reset: the policy returns to earliest deadline, one task scanned, time,
// queue and pending flags cleared; task and job contents are not cleared.
// A stalled receiver holds the result register; the engine then waits and
// the front end keeps taking requests until its buffer is full.
`default_nettype none
module tick_task_scheduler_core #(
    parameter int MAX_TASKS   = tts_pkg::MAX_TASKS_DEF,
    parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = tts_pkg::TIME_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tts_in_if.sink                              i_in,
    tts_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [tts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    tts_pkg::t_item w_item;
    logic           w_item_valid;
    logic           w_item_pop;

    tts_front #(
        .MAX_TASKS (MAX_TASKS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    tts_engine #(
        .MAX_TASKS   (MAX_TASKS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out        (o_out)
    );
endmodule
`default_nettype wire

FILE: verif/tick_task_scheduler_core_tb.sv
// Self-checking testbench for the tick task scheduler core.
`timescale 1ns / 1ps
`default_nettype none
module tick_task_scheduler_core_tb;

    typedef struct {
        logic        cmd;
        logic [3:0]  slot;
        logic [15:0] rel;
        logic [15:0] exe;
        logic [15:0] dl;
        logic [15:0] per;
        logic        pre;
    } t_req;

    typedef struct {
        logic        busy_res;
        logic [3:0]  running_task;
        logic        switched;
        logic        job_done;
        logic        deadline_met;
        logic [15:0] wait_ticks;
        logic        queue_overflow;
        logic [15:0] tick_time;
    } t_report;

    typedef struct {
        logic [3:0]  owner;
        logic [15:0] remaining;
        logic [15:0] deadline;
        logic [15:0] released;
    } t_job;

    localparam int TASKS = 16;
    localparam int QDEPTH = 16;
    localparam int SETTLE = 200;
    localparam longint LIMIT = 3000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [tts_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tts_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tts_in_if req_if ();
    tts_out_if rpt_if ();

    tick_task_scheduler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if.sink),
        .o_out      (rpt_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Scheduler mirror state
    logic [1:0]  sel_policy;
    logic [4:0]  scan_count;
    logic [15:0] next_rel [TASKS];
    logic [15:0] exec_of [TASKS];
    logic [15:0] dl_of [TASKS];
    logic [15:0] period_of [TASKS];
    logic        preempt_of [TASKS];
    logic        armed [TASKS];
    t_job        jobs [$];
    logic [15:0] clock_now;
    int          running_idx;
    logic        in_progress;
    logic [3:0]  prev_task;
    logic        prev_valid;

    t_req    pending_reqs [$];
    t_report expected_reports [$];
    logic [15:0] gen_now;
    int  failures = 0;
    int  reports_seen = 0;
    int  requests_sent = 0;
    int  overflow_seen = 0;
    int  done_seen = 0;
    bit  calm = 0;
    longint cycles = 0;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint job_key(t_job j);
        if (sel_policy == tts_pkg::POL_SRT) return longint'(j.remaining);
        if (sel_policy == tts_pkg::POL_EDF) return longint'(j.deadline);
        return longint'(j.deadline) - longint'(clock_now) - longint'(j.remaining);
    endfunction

    // Apply one accepted request to the mirror; ticks yield one report
    task automatic schedule_request(t_req r);
        int n;
        int pick;
        logic [15:0] rel;
        logic [15:0] dl;
        logic [15:0] fin;
        t_job j;
        t_report rp;
        longint a;
        longint b;
        if (r.cmd == tts_pkg::CMD_LOAD) begin
            next_rel[r.slot] = r.rel;
            exec_of[r.slot] = r.exe;
            dl_of[r.slot] = r.dl;
            period_of[r.slot] = r.per;
            preempt_of[r.slot] = r.pre;
            armed[r.slot] = 1'b1;
            return;
        end
        rp = '{default: '0};
        n = (scan_count > TASKS) ? TASKS : scan_count;
        // Release due tasks into the job queue
        for (int i = 0; i < n; i++) begin
            if (!armed[i] || next_rel[i] > clock_now) continue;
            rel = next_rel[i];
            if (period_of[i] == 16'd0) begin
                armed[i] = 1'b0;
                dl = dl_of[i];
            end else begin
                next_rel[i] = rel + period_of[i];
                dl = next_rel[i];
            end
            if (jobs.size() < QDEPTH) begin
                j.owner = i[3:0];
                j.remaining = exec_of[i];
                j.deadline = dl;
                j.released = rel;
                jobs = {jobs, j};
            end else begin
                rp.queue_overflow = 1'b1;
            end
        end
        rp.tick_time = clock_now;
        if (jobs.size() == 0) begin
            in_progress = 1'b0;
            prev_valid = 1'b0;
        end else begin
            // Keep a running non-preemptible job, else select by policy
            if (in_progress && running_idx < jobs.size() &&
                !preempt_of[jobs[running_idx].owner]) begin
                pick = running_idx;
            end else begin
                pick = 0;
                for (int k = 1; k < jobs.size(); k++) begin
                    a = job_key(jobs[k]);
                    b = job_key(jobs[pick]);
                    if (a < b || (a == b && jobs[k].owner < jobs[pick].owner)) pick = k;
                end
            end
            j = jobs[pick];
            rp.busy_res = 1'b1;
            rp.running_task = j.owner;
            rp.switched = !prev_valid || prev_task != j.owner;
            if (j.remaining <= 16'd1) begin
                fin = clock_now + 16'd1;
                rp.job_done = 1'b1;
                rp.deadline_met = fin <= j.deadline;
                rp.wait_ticks = fin - j.released - exec_of[j.owner];
                jobs.delete(pick);
                in_progress = 1'b0;
                running_idx = 0;
                prev_valid = 1'b0;
            end else begin
                jobs[pick].remaining = j.remaining - 16'd1;
                in_progress = 1'b1;
                running_idx = pick;
                prev_task = j.owner;
                prev_valid = 1'b1;
            end
        end
        clock_now = clock_now + 16'd1;
        expected_reports = {expected_reports, rp};
    endtask

    // Request driver: feed pending requests with random idle bursts
    int gap = 0;
    t_req cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                schedule_request(cur);
                requests_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur = pending_reqs.pop_front();
                    req_if.cmd <= cur.cmd;
                    req_if.task_slot <= cur.slot;
                    req_if.release_time <= cur.rel;
                    req_if.exec_time <= cur.exe;
                    req_if.first_deadline <= cur.dl;
                    req_if.period <= cur.per;
                    req_if.preemptible <= cur.pre;
                    req_if.valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 4);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor: random stalls, compare against oldest expectation
    int stall = 0;
    t_report exp_rp;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rpt_if.ready <= 1'b0;
            stall <= 0;
        end else begin
            if (rpt_if.valid && rpt_if.ready) begin
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected report at tick_time %0d", rpt_if.tick_time);
                    failures++;
                end else begin
                    exp_rp = expected_reports.pop_front();
                    if (exp_rp.queue_overflow) overflow_seen++;
                    if (exp_rp.job_done) done_seen++;
                    if (rpt_if.busy_res !== exp_rp.busy_res) begin
                        $error("busy_res: expected %0d got %0d", exp_rp.busy_res,
                               rpt_if.busy_res);
                        failures++;
                    end
                    if (rpt_if.running_task !== exp_rp.running_task) begin
                        $error("running_task: expected %0d got %0d",
                               exp_rp.running_task, rpt_if.running_task);
                        failures++;
                    end
                    if (rpt_if.switched !== exp_rp.switched) begin
                        $error("switched: expected %0d got %0d", exp_rp.switched,
                               rpt_if.switched);
                        failures++;
                    end
                    if (rpt_if.job_done !== exp_rp.job_done) begin
                        $error("job_done: expected %0d got %0d", exp_rp.job_done,
                               rpt_if.job_done);
                        failures++;
                    end
                    if (rpt_if.deadline_met !== exp_rp.deadline_met) begin
                        $error("deadline_met: expected %0d got %0d",
                               exp_rp.deadline_met, rpt_if.deadline_met);
                        failures++;
                    end
                    if (rpt_if.wait_ticks !== exp_rp.wait_ticks) begin
                        $error("wait_ticks: expected %0d got %0d", exp_rp.wait_ticks,
                               rpt_if.wait_ticks);
                        failures++;
                    end
                    if (rpt_if.queue_overflow !== exp_rp.queue_overflow) begin
                        $error("queue_overflow: expected %0d got %0d",
                               exp_rp.queue_overflow, rpt_if.queue_overflow);
                        failures++;
                    end
                    if (rpt_if.tick_time !== exp_rp.tick_time) begin
                        $error("tick_time: expected %0d got %0d", exp_rp.tick_time,
                               rpt_if.tick_time);
                        failures++;
                    end
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                rpt_if.ready <= 1'b0;
            end else begin
                rpt_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) stall <= $urandom_range(1, 4);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_load(logic [3:0] s, logic [15:0] rel, logic [15:0] exe,
                            logic [15:0] dl, logic [15:0] per, logic pre);
        t_req r;
        r = '{cmd: tts_pkg::CMD_LOAD, slot: s, rel: rel, exe: exe, dl: dl, per: per,
              pre: pre};
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic add_tick();
        t_req r;
        r = '{cmd: tts_pkg::CMD_TICK, slot: 4'($urandom), rel: 16'($urandom),
              exe: 16'($urandom), dl: 16'($urandom), per: 16'($urandom),
              pre: 1'($urandom)};
        pending_reqs = {pending_reqs, r};
        gen_now = gen_now + 16'd1;
    endtask

    // Hold until every request is in and every report out, then settle
    task automatic drain();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || expected_reports.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [tts_pkg::CFG_IDX_W-1:0] idx,
                             logic [tts_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tts_pkg::CFG_POLICY) sel_policy = val[1:0];
        else scan_count = val;
    endtask

    // Park every slot far in the future so old periodic tasks stop releasing
    task automatic park_slots();
        for (int s = 0; s < TASKS; s++) add_load(s[3:0], 16'hFFFF, 16'd1, 16'd0, 16'd0, 1'b0);
    endtask

    task automatic random_run(int count);
        int s;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 3) begin
                s = $urandom_range(0, 15);
                if ($urandom_range(0, 15) == 0)
                    add_load(s[3:0], 16'($urandom), 16'($urandom_range(1, 65535)),
                             16'($urandom), 16'($urandom), 1'($urandom));
                else
                    add_load(s[3:0], gen_now + 16'($urandom_range(0, 20)),
                             16'($urandom_range(1, 8)),
                             gen_now + 16'($urandom_range(0, 60)),
                             ($urandom_range(0, 9) < 4) ? 16'd0 : 16'($urandom_range(10, 60)),
                             1'($urandom));
            end else begin
                add_tick();
            end
        end
    endtask

    initial begin
        sel_policy = tts_pkg::POLICY_RESET;
        scan_count = tts_pkg::TASKS_RESET;
        foreach (armed[i]) armed[i] = 1'b0;
        clock_now = '0;
        running_idx = 0;
        in_progress = 1'b0;
        prev_task = '0;
        prev_valid = 1'b0;
        gen_now = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tts_pkg::CFG_POLICY;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.cmd = tts_pkg::CMD_LOAD;
        req_if.task_slot = '0;
        req_if.release_time = '0;
        req_if.exec_time = '0;
        req_if.first_deadline = '0;
        req_if.period = '0;
        req_if.preemptible = 1'b0;
        rpt_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: idle tick, missed deadline, unscanned slot
        add_tick();
        add_load(4'd0, 16'd0, 16'd1, 16'd0, 16'd0, 1'b1);
        add_load(4'd15, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        add_tick();
        add_tick();
        drain();

        // Shortest remaining, all slots: non-preemptible hold, ties, overflow
        write_reg(tts_pkg::CFG_POLICY, 5'(tts_pkg::POL_SRT));
        write_reg(tts_pkg::CFG_TASKS, 5'd16);
        add_load(4'd3, gen_now, 16'd3, gen_now + 16'd2, 16'd0, 1'b0);
        add_tick();
        add_load(4'd1, gen_now, 16'd1, gen_now + 16'd9, 16'd0, 1'b1);
        add_load(4'd2, gen_now, 16'd1, gen_now + 16'd9, 16'd0, 1'b1);
        add_tick();
        add_tick();
        add_tick();
        add_tick();
        for (int s = 0; s < TASKS; s++)
            add_load(s[3:0], gen_now, 16'd2, 16'd0, 16'd1, 1'b1);
        add_tick();
        add_tick();
        drain();

        // Random phases across policies and scan widths, extremes included
        write_reg(tts_pkg::CFG_POLICY, 5'(tts_pkg::POL_LST));
        park_slots();
        random_run(150);
        drain();
        write_reg(tts_pkg::CFG_POLICY, 5'd3);
        write_reg(tts_pkg::CFG_TASKS, 5'd31);
        random_run(140);
        drain();
        write_reg(tts_pkg::CFG_TASKS, 5'd0);
        random_run(40);
        drain();
        write_reg(tts_pkg::CFG_POLICY, 5'(tts_pkg::POL_EDF));
        write_reg(tts_pkg::CFG_TASKS, 5'd8);
        park_slots();
        random_run(150);
        drain();
        write_reg(tts_pkg::CFG_POLICY, 5'(tts_pkg::POL_SRT));
        write_reg(tts_pkg::CFG_TASKS, 5'd16);
        random_run(130);
        drain();
        calm = 1;
        write_reg(tts_pkg::CFG_POLICY, 5'(tts_pkg::POL_LST));
        write_reg(tts_pkg::CFG_TASKS, 5'd17);
        random_run(150);
        drain();

        $display("Ran %0d requests, checked %0d reports (%0d completions, %0d overflows)",
                 requests_sent, reports_seen, done_seen, overflow_seen);
        $display("Covered all four policy codes and scan widths 0, 1, 8, 16, 17, 31");
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
